>>> rtl/gsbs_pkg.sv
// ----------------------------------------------------------------------------
// gsbs_pkg: shared types and constants of the gas sensor blow sequencer
// Phase, action and register codes plus the item, state and config structs.
// ----------------------------------------------------------------------------
package gsbs_pkg;

  // field widths fixed by the item formats
  localparam int PhaseW  = 3;
  localparam int ActionW = 2;
  localparam int TimeW   = 32;
  localparam int SampleW = 12;
  localparam int PctW    = 7;
  localparam int DutyW   = 8;
  localparam int RegIdxW = 3;
  localparam int CfgDataW = 32;

  // full scale of a percent setting
  localparam int PctFull = 100;
  localparam logic [PctW-1:0] PctMax = PctW'(PctFull);

  // phase codes
  localparam logic [PhaseW-1:0] PhIdle  = 3'd0;
  localparam logic [PhaseW-1:0] PhHeat  = 3'd1;
  localparam logic [PhaseW-1:0] PhBlow  = 3'd2;
  localparam logic [PhaseW-1:0] PhRetry = 3'd3;
  localparam logic [PhaseW-1:0] PhDone  = 3'd4;

  // action codes
  localparam logic [ActionW-1:0] ActTick  = 2'd0;
  localparam logic [ActionW-1:0] ActStart = 2'd1;
  localparam logic [ActionW-1:0] ActStop  = 2'd2;
  localparam logic [ActionW-1:0] ActNone  = 2'd3;

  // configuration register indexes
  localparam logic [RegIdxW-1:0] RegMicThreshold = 3'd0;
  localparam logic [RegIdxW-1:0] RegHeatingTime  = 3'd1;
  localparam logic [RegIdxW-1:0] RegBlowHold     = 3'd2;
  localparam logic [RegIdxW-1:0] RegGrace        = 3'd3;
  localparam logic [RegIdxW-1:0] RegRetryShow    = 3'd4;
  localparam logic [RegIdxW-1:0] RegBuzzerLevel  = 3'd5;
  localparam logic [RegIdxW-1:0] RegHeaterLevel  = 3'd6;
  localparam logic [RegIdxW-1:0] RegHeaterPol    = 3'd7;

  // configuration reset values
  localparam logic [SampleW-1:0] MicThresholdRst = 12'd1200;
  localparam logic [TimeW-1:0]   HeatingTimeRst  = 32'd20000;
  localparam logic [TimeW-1:0]   BlowHoldRst     = 32'd1000;
  localparam logic [TimeW-1:0]   GraceRst        = 32'd400;
  localparam logic [TimeW-1:0]   RetryShowRst    = 32'd1500;
  localparam logic [PctW-1:0]    BuzzerLevelRst  = 7'd80;
  localparam logic [PctW-1:0]    HeaterLevelRst  = 7'd100;

  typedef struct packed {
    logic [SampleW-1:0] mic_threshold;
    logic [TimeW-1:0]   heating_time_ms;
    logic [TimeW-1:0]   blow_hold_ms;
    logic [TimeW-1:0]   grace_ms;
    logic [TimeW-1:0]   retry_show_ms;
    logic [PctW-1:0]    buzzer_level;
    logic [PctW-1:0]    heater_level;
    logic               heater_polarity_high;
  } gsbs_cfg_t;

  typedef struct packed {
    logic [PhaseW-1:0]  phase;
    logic [TimeW-1:0]   phase_start;
    logic [TimeW-1:0]   blow_start;
    logic [TimeW-1:0]   last_above;
    logic [TimeW-1:0]   retry_until;
    logic               blowing;
    logic [SampleW-1:0] mic_hold;
    logic [SampleW-1:0] gas_hold;
    logic               heater_on;
    logic               buzzer_on;
  } gsbs_state_t;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [TimeW-1:0]   now_ms;
    logic [SampleW-1:0] mic_sample;
    logic [SampleW-1:0] gas_sample;
  } gsbs_in_t;

  typedef struct packed {
    logic [PhaseW-1:0]  phase_code;
    logic [DutyW-1:0]   heater_duty;
    logic               buzzer_active;
    logic [PctW-1:0]    buzzer_drive;
    logic [SampleW-1:0] gas_result;
    logic [SampleW-1:0] mic_latest;
    logic [TimeW-1:0]   heat_left_ms;
  } gsbs_out_t;

endpackage

>>> rtl/gsbs_in_if.sv
// ----------------------------------------------------------------------------
// gsbs_in_if: command and sample channel
// Carries one tick, start or stop command with its timestamp and samples.
// ----------------------------------------------------------------------------
interface gsbs_in_if
  import gsbs_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [ActionW-1:0] action;
  logic [TimeW-1:0]   now_ms;
  logic [SampleW-1:0] mic_sample;
  logic [SampleW-1:0] gas_sample;

  modport source (output valid, action, now_ms, mic_sample, gas_sample, input ready);
  modport sink   (input valid, action, now_ms, mic_sample, gas_sample, output ready);
endinterface

>>> rtl/gsbs_out_if.sv
// ----------------------------------------------------------------------------
// gsbs_out_if: status channel
// Carries the phase, drive levels and latched readings after each command.
// ----------------------------------------------------------------------------
interface gsbs_out_if
  import gsbs_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [PhaseW-1:0]  phase_code;
  logic [DutyW-1:0]   heater_duty;
  logic               buzzer_active;
  logic [PctW-1:0]    buzzer_drive;
  logic [SampleW-1:0] gas_result;
  logic [SampleW-1:0] mic_latest;
  logic [TimeW-1:0]   heat_left_ms;

  modport source (output valid, phase_code, heater_duty, buzzer_active, buzzer_drive,
                  gas_result, mic_latest, heat_left_ms, input ready);
  modport sink   (input valid, phase_code, heater_duty, buzzer_active, buzzer_drive,
                  gas_result, mic_latest, heat_left_ms, output ready);
endinterface

>>> rtl/gsbs_cfg_if.sv
// ----------------------------------------------------------------------------
// gsbs_cfg_if: configuration write channel
// Carries a register index and the data to write there.
// ----------------------------------------------------------------------------
interface gsbs_cfg_if
  import gsbs_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [RegIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/gsbs_step.sv
// ----------------------------------------------------------------------------
// gsbs_step: sequencer next-state and status logic
// Applies one command to the sequencer state and forms the status item.
// ----------------------------------------------------------------------------
module gsbs_step
  import gsbs_pkg::*;
#(
  parameter int PWM_BITS = 8,
  parameter int ADC_BITS = 12
) (
  input  gsbs_cfg_t   cfg_i,
  input  gsbs_state_t state_i,
  input  gsbs_in_t    item_i,
  output gsbs_state_t state_o,
  output gsbs_out_t   result_o
);

  localparam int MaxDuty = (1 << PWM_BITS) - 1;
  localparam int AdcKeep = (ADC_BITS < SampleW) ? ADC_BITS : SampleW;
  localparam logic [SampleW-1:0] SampleMask = SampleW'((1 << AdcKeep) - 1);
  localparam int DutyWideW = (PWM_BITS > DutyW) ? PWM_BITS : DutyW;
  localparam logic [PWM_BITS-1:0] DutyFull = PWM_BITS'(MaxDuty);

  logic [PWM_BITS-1:0] duty_lut [PctFull+1];
  logic [SampleW-1:0]  mic;
  logic [SampleW-1:0]  gas;
  logic [TimeW-1:0]    now;
  logic [TimeW-1:0]    heat_el;
  logic [TimeW-1:0]    left_el;
  logic [TimeW-1:0]    blow_start_new;
  logic [PctW-1:0]     heater_pct;
  logic [PctW-1:0]     buzzer_pct;
  logic [PWM_BITS-1:0] duty_raw;
  logic [PWM_BITS-1:0] duty_pol;
  logic [DutyWideW-1:0] duty_wide;
  gsbs_state_t         nxt;

  // percent to duty table, settled at elaboration
  for (genvar g = 0; g <= PctFull; g++) begin : g_duty
    assign duty_lut[g] = PWM_BITS'((g * MaxDuty) / PctFull);
  end

  assign mic = item_i.mic_sample & SampleMask;
  assign gas = item_i.gas_sample & SampleMask;
  assign now = item_i.now_ms;
  assign heat_el = now - state_i.phase_start;
  assign blow_start_new = state_i.blowing ? state_i.blow_start : now;

  // phase sequencing
  always_comb begin
    nxt = state_i;
    unique case (item_i.action)
      ActStart: begin
        nxt.phase       = PhHeat;
        nxt.phase_start = now;
        nxt.blow_start  = '0;
        nxt.last_above  = '0;
        nxt.retry_until = '0;
        nxt.blowing     = 1'b0;
        nxt.gas_hold    = '0;
        nxt.heater_on   = 1'b1;
      end
      ActStop: begin
        nxt.phase     = PhIdle;
        nxt.heater_on = 1'b0;
      end
      ActTick: begin
        priority if (state_i.phase == PhHeat || state_i.phase == PhRetry) begin
          // heating done, or retry deadline reached (plain unsigned compare)
          if ((state_i.phase == PhHeat && heat_el >= cfg_i.heating_time_ms) ||
              (state_i.phase == PhRetry && now >= state_i.retry_until)) begin
            nxt.phase       = PhBlow;
            nxt.phase_start = now;
            nxt.blowing     = 1'b0;
            nxt.last_above  = '0;
          end
        end else if (state_i.phase == PhBlow) begin
          nxt.mic_hold = mic;
          if (mic >= cfg_i.mic_threshold) begin
            nxt.blowing    = 1'b1;
            nxt.blow_start = blow_start_new;
            nxt.last_above = now;
            nxt.buzzer_on  = 1'b1;
            if (now - blow_start_new >= cfg_i.blow_hold_ms) begin
              nxt.gas_hold  = gas;
              nxt.buzzer_on = 1'b0;
              nxt.phase     = PhDone;
              nxt.heater_on = 1'b0;
            end
          end else begin
            nxt.buzzer_on = 1'b0;
            if (state_i.blowing && (now - state_i.last_above > cfg_i.grace_ms)) begin
              nxt.phase       = PhRetry;
              nxt.retry_until = now + cfg_i.retry_show_ms;
              nxt.blowing     = 1'b0;
            end
          end
        end else begin
          // idle and done ignore ticks
        end
      end
      ActNone: begin
      end
      default: begin
      end
    endcase
  end

  // elapsed time since the start of the current phase
  assign left_el = now - nxt.phase_start;

  // drive levels, clamped to full scale
  assign heater_pct = (cfg_i.heater_level > PctMax) ? PctMax : cfg_i.heater_level;
  assign buzzer_pct = (cfg_i.buzzer_level > PctMax) ? PctMax : cfg_i.buzzer_level;
  assign duty_raw   = nxt.heater_on ? duty_lut[heater_pct] : '0;
  assign duty_pol   = cfg_i.heater_polarity_high ? duty_raw : (DutyFull - duty_raw);
  assign duty_wide  = DutyWideW'(duty_pol);

  // status item
  always_comb begin
    result_o.phase_code    = nxt.phase;
    result_o.heater_duty   = duty_wide[DutyW-1:0];
    result_o.buzzer_active = nxt.buzzer_on;
    result_o.buzzer_drive  = nxt.buzzer_on ? buzzer_pct : '0;
    result_o.gas_result    = nxt.gas_hold;
    result_o.mic_latest    = nxt.mic_hold;
    result_o.heat_left_ms  = '0;
    if (nxt.phase == PhHeat && left_el < cfg_i.heating_time_ms) begin
      result_o.heat_left_ms = cfg_i.heating_time_ms - left_el;
    end
  end

  assign state_o = nxt;

endmodule

>>> rtl/gas_sensor_blow_sequencer.sv
// ----------------------------------------------------------------------------
// gas_sensor_blow_sequencer: heated gas-sensor breath test sequencer
// Steps idle, heating, blow, retry and done phases on timestamped commands.
// ----------------------------------------------------------------------------
//  channel   dir  role     payload
//  in_i      in   sink     action, now_ms, mic_sample, gas_sample
//  out_o     out  source   phase_code, heater_duty, buzzer_*, gas_result,
//                          mic_latest, heat_left_ms
//  cfg_i     in   sink     index, data (always ready)
//
//  one command per cycle sustained while out_o.ready stays high; each command
//  passes through the input register, then the status register, which offers
//  its status item on out_o
//  the status register stalls on out_o.ready low and the input register backs
//  up behind it, so in_i.ready drops only when both stages hold an item
//  reset empties both stages, clears the sequencer state and returns the
//  config registers to their defaults
// ----------------------------------------------------------------------------
module gas_sensor_blow_sequencer
  import gsbs_pkg::*;
#(
  parameter int PWM_BITS = 8,
  parameter int ADC_BITS = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gsbs_in_if.sink    in_i,
  gsbs_out_if.source out_o,
  gsbs_cfg_if.sink   cfg_i
);

  gsbs_cfg_t   cfg_q;
  gsbs_state_t state_q;
  gsbs_state_t state_d;
  gsbs_in_t    item_q;
  gsbs_out_t   res_q;
  gsbs_out_t   res_d;
  logic        item_valid_q;
  logic        res_valid_q;
  logic        res_load;
  logic        in_xfer;

  // handshakes
  assign res_load   = item_valid_q && (!res_valid_q || out_o.ready);
  assign in_i.ready = !item_valid_q || res_load;
  assign in_xfer    = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mic_threshold        <= MicThresholdRst;
      cfg_q.heating_time_ms      <= HeatingTimeRst;
      cfg_q.blow_hold_ms         <= BlowHoldRst;
      cfg_q.grace_ms             <= GraceRst;
      cfg_q.retry_show_ms        <= RetryShowRst;
      cfg_q.buzzer_level         <= BuzzerLevelRst;
      cfg_q.heater_level         <= HeaterLevelRst;
      cfg_q.heater_polarity_high <= 1'b1;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        RegMicThreshold: cfg_q.mic_threshold        <= cfg_i.data[SampleW-1:0];
        RegHeatingTime:  cfg_q.heating_time_ms      <= cfg_i.data[TimeW-1:0];
        RegBlowHold:     cfg_q.blow_hold_ms         <= cfg_i.data[TimeW-1:0];
        RegGrace:        cfg_q.grace_ms             <= cfg_i.data[TimeW-1:0];
        RegRetryShow:    cfg_q.retry_show_ms        <= cfg_i.data[TimeW-1:0];
        RegBuzzerLevel:  cfg_q.buzzer_level         <= cfg_i.data[PctW-1:0];
        RegHeaterLevel:  cfg_q.heater_level         <= cfg_i.data[PctW-1:0];
        RegHeaterPol:    cfg_q.heater_polarity_high <= cfg_i.data[0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      item_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.action     <= in_i.action;
      item_q.now_ms     <= in_i.now_ms;
      item_q.mic_sample <= in_i.mic_sample;
      item_q.gas_sample <= in_i.gas_sample;
    end
  end

  // sequencer step
  gsbs_step #(
    .PWM_BITS (PWM_BITS),
    .ADC_BITS (ADC_BITS)
  ) u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // sequencer state, advanced as each item moves to the status register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase       <= PhIdle;
      state_q.phase_start <= '0;
      state_q.blow_start  <= '0;
      state_q.last_above  <= '0;
      state_q.retry_until <= '0;
      state_q.blowing     <= 1'b0;
      state_q.mic_hold    <= '0;
      state_q.gas_hold    <= '0;
      state_q.heater_on   <= 1'b0;
      state_q.buzzer_on   <= 1'b0;
    end else if (res_load) begin
      state_q <= state_d;
    end
  end

  // status register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (!res_valid_q || out_o.ready) begin
      res_valid_q <= item_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid         = res_valid_q;
  assign out_o.phase_code    = res_q.phase_code;
  assign out_o.heater_duty   = res_q.heater_duty;
  assign out_o.buzzer_active = res_q.buzzer_active;
  assign out_o.buzzer_drive  = res_q.buzzer_drive;
  assign out_o.gas_result    = res_q.gas_result;
  assign out_o.mic_latest    = res_q.mic_latest;
  assign out_o.heat_left_ms  = res_q.heat_left_ms;

endmodule

>>> tb/gsbs_status_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gsbs_status_checker: scoreboard for the gas sensor blow sequencer
// Watches the command, status and register channels. Keeps its own copy of
// the sequencer state and registers, predicts the status for each command
// transfer and compares every status transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module gsbs_status_checker
  import gsbs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  gsbs_in_if          cmd_i,
  gsbs_out_if         status_i,
  gsbs_cfg_if         cfg_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);

  localparam int DutyFull = (1 << DutyW) - 1;

  gsbs_cfg_t   regs;
  gsbs_state_t seq;
  gsbs_out_t   status_q[$];

  // percent settings above full scale act as full scale
  function automatic logic [PctW-1:0] pct_limit(logic [PctW-1:0] pct);
    return (pct > PctMax) ? PctMax : pct;
  endfunction

  function automatic void open_blow(logic [TimeW-1:0] now);
    seq.phase       = PhBlow;
    seq.phase_start = now;
    seq.blowing     = 1'b0;
    seq.last_above  = '0;
  endfunction

  // advance the sequencer copy by one command, return the status after it
  function automatic gsbs_out_t predict_status(gsbs_in_t cmd);
    gsbs_out_t        res;
    logic [TimeW-1:0] elapsed;
    int unsigned      duty;
    res = '0;
    case (cmd.action)
      ActStart: begin
        seq.phase       = PhHeat;
        seq.phase_start = cmd.now_ms;
        seq.blow_start  = '0;
        seq.last_above  = '0;
        seq.retry_until = '0;
        seq.blowing     = 1'b0;
        seq.gas_hold    = '0;
        seq.heater_on   = 1'b1;
      end
      // stop leaves the buzzer as it was
      ActStop: begin
        seq.phase     = PhIdle;
        seq.heater_on = 1'b0;
      end
      ActTick: begin
        if (seq.phase == PhHeat) begin
          if (cmd.now_ms - seq.phase_start >= regs.heating_time_ms) open_blow(cmd.now_ms);
        end else if (seq.phase == PhRetry) begin
          // plain unsigned compare, no wrap handling
          if (cmd.now_ms >= seq.retry_until) open_blow(cmd.now_ms);
        end else if (seq.phase == PhBlow) begin
          seq.mic_hold = cmd.mic_sample;
          if (cmd.mic_sample >= regs.mic_threshold) begin
            if (!seq.blowing) begin
              seq.blowing    = 1'b1;
              seq.blow_start = cmd.now_ms;
            end
            seq.last_above = cmd.now_ms;
            seq.buzzer_on  = 1'b1;
            if (cmd.now_ms - seq.blow_start >= regs.blow_hold_ms) begin
              seq.gas_hold  = cmd.gas_sample;
              seq.buzzer_on = 1'b0;
              seq.phase     = PhDone;
              seq.heater_on = 1'b0;
            end
          end else begin
            seq.buzzer_on = 1'b0;
            if (seq.blowing && (cmd.now_ms - seq.last_above > regs.grace_ms)) begin
              seq.phase       = PhRetry;
              seq.retry_until = cmd.now_ms + regs.retry_show_ms;
              seq.blowing     = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase

    // remaining heat time only while heating
    if (seq.phase == PhHeat) begin
      elapsed = cmd.now_ms - seq.phase_start;
      res.heat_left_ms = (elapsed >= regs.heating_time_ms) ? '0
                                                           : regs.heating_time_ms - elapsed;
    end

    duty = seq.heater_on ? (pct_limit(regs.heater_level) * DutyFull) / PctFull : 0;
    if (!regs.heater_polarity_high) duty = DutyFull - duty;

    res.phase_code    = seq.phase;
    res.heater_duty   = DutyW'(duty);
    res.buzzer_active = seq.buzzer_on;
    res.buzzer_drive  = seq.buzzer_on ? pct_limit(regs.buzzer_level) : '0;
    res.gas_result    = seq.gas_hold;
    res.mic_latest    = seq.mic_hold;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [TimeW-1:0] want,
                             input logic [TimeW-1:0] got, inout int unsigned bad);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      bad++;
    end
  endtask

  // compare status transfers, track register writes, predict on commands
  always @(posedge clk_i or negedge rst_ni) begin : track
    gsbs_in_t    cmd;
    gsbs_out_t   want;
    int unsigned bad;
    if (!rst_ni) begin
      regs.mic_threshold        = MicThresholdRst;
      regs.heating_time_ms      = HeatingTimeRst;
      regs.blow_hold_ms         = BlowHoldRst;
      regs.grace_ms             = GraceRst;
      regs.retry_show_ms        = RetryShowRst;
      regs.buzzer_level         = BuzzerLevelRst;
      regs.heater_level         = HeaterLevelRst;
      regs.heater_polarity_high = 1'b1;
      seq       = '0;
      seq.phase = PhIdle;
      status_q.delete();
      mismatch_count_o <= 0;
      pending_o        <= 0;
    end else begin
      bad = 0;
      // compare before predicting, so a status is never checked against a command taken now
      if (status_i.valid && status_i.ready) begin
        if (status_q.size() == 0) begin
          $error("status transfer with no prediction outstanding");
          bad++;
        end else begin
          want = status_q.pop_front();
          check_field("phase_code", want.phase_code, status_i.phase_code, bad);
          check_field("heater_duty", want.heater_duty, status_i.heater_duty, bad);
          check_field("buzzer_active", want.buzzer_active, status_i.buzzer_active, bad);
          check_field("buzzer_drive", want.buzzer_drive, status_i.buzzer_drive, bad);
          check_field("gas_result", want.gas_result, status_i.gas_result, bad);
          check_field("mic_latest", want.mic_latest, status_i.mic_latest, bad);
          check_field("heat_left_ms", want.heat_left_ms, status_i.heat_left_ms, bad);
        end
      end

      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          RegMicThreshold: regs.mic_threshold        = cfg_i.data[SampleW-1:0];
          RegHeatingTime:  regs.heating_time_ms      = cfg_i.data;
          RegBlowHold:     regs.blow_hold_ms         = cfg_i.data;
          RegGrace:        regs.grace_ms             = cfg_i.data;
          RegRetryShow:    regs.retry_show_ms        = cfg_i.data;
          RegBuzzerLevel:  regs.buzzer_level         = cfg_i.data[PctW-1:0];
          RegHeaterLevel:  regs.heater_level         = cfg_i.data[PctW-1:0];
          RegHeaterPol:    regs.heater_polarity_high = cfg_i.data[0];
          default: ;
        endcase
      end

      if (cmd_i.valid && cmd_i.ready) begin
        cmd.action     = cmd_i.action;
        cmd.now_ms     = cmd_i.now_ms;
        cmd.mic_sample = cmd_i.mic_sample;
        cmd.gas_sample = cmd_i.gas_sample;
        status_q.push_back(predict_status(cmd));
      end

      mismatch_count_o <= mismatch_count_o + bad;
      pending_o        <= status_q.size();
    end
  end

endmodule

>>> tb/tb_gas_sensor_blow_sequencer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gas_sensor_blow_sequencer: testbench top for the blow sequencer
// Resets the block, runs a directed sequence through every phase and then
// random measurement sessions under several register settings, with random
// gaps on the command side and random stalls on the status side. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_gas_sensor_blow_sequencer;
  import gsbs_pkg::*;

  localparam int LimitCycles  = 500_000;
  localparam int ResetCycles  = 8;
  localparam int DrainCycles  = 6;
  localparam int LongHold     = 300;
  localparam int PhaseItems   = 128;
  localparam int RandomPhases = 8;

  logic        clk;
  logic        rst_n;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned results_seen;
  int unsigned cycles;
  int unsigned cmds_sent;
  bit          quiet_sender;

  gsbs_in_if  in_if ();
  gsbs_out_if out_if ();
  gsbs_cfg_if cfg_if ();

  gas_sensor_blow_sequencer u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  gsbs_status_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cmd_i            (in_if),
    .status_i         (out_if),
    .cfg_i            (cfg_if),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // one command transfer, returns at the edge where it was taken
  task automatic send_cmd(input logic [ActionW-1:0] act, input logic [TimeW-1:0] stamp_v,
                          input logic [SampleW-1:0] mic_v, input logic [SampleW-1:0] gas_v);
    int unsigned gap;
    gap = quiet_sender ? 0 : pick_gap();
    repeat (gap) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.action     <= act;
    in_if.now_ms     <= stamp_v;
    in_if.mic_sample <= mic_v;
    in_if.gas_sample <= gas_v;
    do @(posedge clk); while (!in_if.ready);
    cmds_sent++;
  endtask

  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  // stop offering and wait until every status has come back
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // count status transfers for the long hold trigger
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      results_seen <= 0;
    end else if (out_if.valid && out_if.ready) begin
      results_seen <= results_seen + 1;
    end
  end

  // status side: ready runs and stalls, plus two long holds
  initial begin : status_sink
    int unsigned run;
    int unsigned holds;
    holds = 0;
    out_if.ready <= 1'b0;
    wait (rst_n);
    forever begin
      if (holds < 2 && results_seen >= 200 + 500 * holds) begin
        // sender keeps offering so both stages fill and input ready drops
        repeat (LongHold) begin
          @(posedge clk);
          out_if.ready <= 1'b0;
        end
        holds++;
      end
      run = $urandom_range(1, 40);
      repeat (run) begin
        @(posedge clk);
        out_if.ready <= 1'b1;
      end
      repeat (pick_gap()) begin
        @(posedge clk);
        out_if.ready <= 1'b0;
      end
    end
  end

  // watchdog
  initial begin : watchdog
    cycles = 0;
    while (cycles < LimitCycles) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  // stimulus and verdict
  initial begin : stimulus
    logic [TimeW-1:0]    stamp;
    logic [SampleW-1:0]  stim_thr;
    logic [SampleW-1:0]  thr;
    logic [SampleW-1:0]  mic;
    logic [TimeW-1:0]    heat, hold, grace, retry;
    logic [PctW-1:0]     buzz, heater;
    logic                pol;
    logic [CfgDataW-1:0] noise;
    bit                  above;
    int unsigned         phase_end;
    int unsigned         ticks;

    rst_n            = 1'b0;
    cmds_sent        = 0;
    quiet_sender     = 1'b0;
    in_if.valid      <= 1'b0;
    in_if.action     <= ActTick;
    in_if.now_ms     <= '0;
    in_if.mic_sample <= '0;
    in_if.gas_sample <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= RegMicThreshold;
    cfg_if.data      <= '0;
    stim_thr = MicThresholdRst;
    stamp    = '0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: tick while idle, unused action, wrapped heating, stop
    send_cmd(ActTick, '0, '0, '0);
    send_cmd(ActNone, '1, '1, '1);
    send_cmd(ActStart, 32'hFFFF_FF00, 12'hFFF, 12'hFFF);
    send_cmd(ActTick, 32'h0000_0100, 12'd0, 12'd5);
    send_cmd(ActStop, 32'h0000_0101, 12'd0, 12'd0);

    // short times, levels above full scale, inverted heater
    wait_drained();
    write_reg(RegHeatingTime, 32'd5);
    write_reg(RegBlowHold, 32'd3);
    write_reg(RegGrace, 32'd2);
    write_reg(RegRetryShow, 32'd4);
    write_reg(RegBuzzerLevel, 32'hFFFF_FF7F);
    write_reg(RegHeaterLevel, 32'd101);
    write_reg(RegHeaterPol, 32'hFFFF_FFFE);
    cfg_if.valid <= 1'b0;

    // heating into blow, stop while buzzing, restart
    send_cmd(ActStart, 32'd100, 12'd0, 12'd0);
    send_cmd(ActTick, 32'd104, 12'd0, 12'd0);
    send_cmd(ActTick, 32'd105, 12'd0, 12'd0);
    send_cmd(ActTick, 32'd106, 12'd4095, 12'd7);
    send_cmd(ActStop, 32'd107, 12'd0, 12'd0);
    send_cmd(ActStart, 32'd108, 12'd0, 12'd0);
    send_cmd(ActTick, 32'd113, 12'd0, 12'd0);
    // exactly at threshold, gap within grace, then lost blow into retry
    send_cmd(ActTick, 32'd114, 12'd1200, 12'd0);
    send_cmd(ActTick, 32'd115, 12'd1199, 12'd0);
    send_cmd(ActTick, 32'd118, 12'd0, 12'd0);
    send_cmd(ActTick, 32'd120, 12'd0, 12'd0);
    send_cmd(ActTick, 32'd122, 12'd0, 12'd0);
    // hold met, gas latched, then a tick while done
    send_cmd(ActTick, 32'd123, 12'd3000, 12'd1);
    send_cmd(ActTick, 32'd126, 12'd4095, 12'hABC);
    send_cmd(ActTick, 32'd127, 12'd4095, 12'h555);
    // retry deadline that wraps past zero ends at once
    send_cmd(ActStart, 32'hFFFF_FFF0, 12'd0, 12'd0);
    send_cmd(ActTick, 32'hFFFF_FFF5, 12'd0, 12'd0);
    send_cmd(ActTick, 32'hFFFF_FFF6, 12'd4095, 12'd0);
    send_cmd(ActTick, 32'hFFFF_FFFD, 12'd0, 12'd0);
    send_cmd(ActTick, 32'hFFFF_FFFE, 12'd0, 12'd0);

    // random sessions under several register settings
    for (int p = 0; p < RandomPhases; p++) begin
      wait_drained();
      case (p)
        0: begin
          thr = '0; heat = '0; hold = '0; grace = '0; retry = '0;
          buzz = '0; heater = '0; pol = 1'b1;
        end
        1: begin
          thr = '1; heat = 32'd3; hold = 32'd2; grace = 32'd1; retry = 32'd2;
          buzz = PctMax; heater = PctMax; pol = 1'b0;
        end
        2: begin
          thr = SampleW'($urandom()); heat = '1; hold = 32'd4; grace = '1; retry = 32'd3;
          buzz = '1; heater = '1; pol = 1'b1;
        end
        3: begin
          thr = SampleW'($urandom()); heat = 32'd1; hold = '1; grace = '0; retry = '1;
          buzz = PctW'($urandom_range(0, 127)); heater = PctW'($urandom_range(0, 127));
          pol = 1'b0;
        end
        default: begin
          thr    = SampleW'($urandom_range(0, 4095));
          heat   = $urandom_range(0, 10);
          hold   = $urandom_range(0, 12);
          grace  = $urandom_range(0, 5);
          retry  = $urandom_range(0, 10);
          buzz   = PctW'($urandom_range(0, 127));
          heater = PctW'($urandom_range(0, 127));
          pol    = 1'(($urandom_range(0, 1)));
        end
      endcase
      // masked registers get random upper bits
      noise = $urandom();
      write_reg(RegMicThreshold, {noise[CfgDataW-1:SampleW], thr});
      write_reg(RegHeatingTime, heat);
      write_reg(RegBlowHold, hold);
      write_reg(RegGrace, grace);
      write_reg(RegRetryShow, retry);
      noise = $urandom();
      write_reg(RegBuzzerLevel, {noise[CfgDataW-1:PctW], buzz});
      noise = $urandom();
      write_reg(RegHeaterLevel, {noise[CfgDataW-1:PctW], heater});
      noise = $urandom();
      write_reg(RegHeaterPol, {noise[CfgDataW-1:1], pol});
      cfg_if.valid <= 1'b0;
      stim_thr = thr;

      phase_end = cmds_sent + PhaseItems;
      while (cmds_sent < phase_end) begin
        quiet_sender = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) == 0) begin
          // noise: any action at any time
          send_cmd(ActionW'($urandom_range(0, 3)), $urandom(),
                   SampleW'($urandom()), SampleW'($urandom()));
        end else begin
          // well-formed session, sometimes started just short of the wrap
          if ($urandom_range(0, 7) == 0) stamp = 32'hFFFF_FFFF - $urandom_range(0, 40);
          send_cmd(ActStart, stamp, SampleW'($urandom()), SampleW'($urandom()));
          above = 1'b0;
          ticks = $urandom_range(8, 40);
          repeat (ticks) begin
            if ($urandom_range(0, 29) == 0) stamp = $urandom();
            else stamp = stamp + $urandom_range(0, 3);
            if ($urandom_range(0, 4) == 0) above = !above;
            if ($urandom_range(0, 7) == 0) mic = stim_thr;
            else if (above || stim_thr == 0) mic = SampleW'($urandom_range(stim_thr, 4095));
            else mic = SampleW'($urandom_range(0, stim_thr - 1));
            if ($urandom_range(0, 39) == 0) send_cmd(ActStop, stamp, mic, SampleW'($urandom()));
            else send_cmd(ActTick, stamp, mic, SampleW'($urandom()));
          end
        end
      end
    end

    wait_drained();
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
